// ===== rtl/cls_pkg.sv =====
package cls_pkg;

   localparam int LevelW = 10;
   localparam int CountW = 8;
   localparam int DivW   = 19;
   localparam int RemW   = 10;
   localparam int StepW  = 5;
   localparam int ProdW  = 18;
   localparam int RhsW   = 22;

   // Commands carried by one input beat.
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_OPEN  = 3'd1;
   localparam logic [2:0] CMD_CLOSE = 3'd2;
   localparam logic [2:0] CMD_HALT  = 3'd3;
   localparam logic [2:0] CMD_LON   = 3'd4;
   localparam logic [2:0] CMD_LOFF  = 3'd5;
   localparam logic [2:0] CMD_SETBR = 3'd6;
   localparam logic [2:0] CMD_ESTOP = 3'd7;

   localparam logic [2:0] CV_UNKNOWN = 3'd0;
   localparam logic [2:0] CV_CLOSED  = 3'd1;
   localparam logic [2:0] CV_OPEN    = 3'd2;
   localparam logic [2:0] CV_MOVING  = 3'd3;
   localparam logic [2:0] CV_ABSENT  = 3'd4;

   localparam logic [2:0] LP_UNKNOWN  = 3'd0;
   localparam logic [2:0] LP_OFF      = 3'd1;
   localparam logic [2:0] LP_NOTREADY = 3'd2;
   localparam logic [2:0] LP_READY    = 3'd3;
   localparam logic [2:0] LP_ABSENT   = 3'd4;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_ABSENT = 2'd1;
   localparam logic [1:0] STAT_ESTOP  = 2'd2;
   localparam logic [1:0] STAT_HOT    = 2'd3;

   localparam logic [2:0] REG_MAX_BRIGHT = 3'd0;
   localparam logic [2:0] REG_TRAVEL     = 3'd1;
   localparam logic [2:0] REG_WARMUP     = 3'd2;
   localparam logic [2:0] REG_COOLDOWN   = 3'd3;
   localparam logic [2:0] REG_MAX_TEMP   = 3'd4;
   localparam logic [2:0] REG_COVER_PRES = 3'd5;
   localparam logic [2:0] REG_LAMP_PRES  = 3'd6;
   localparam logic [2:0] REG_MONITOR    = 3'd7;

   localparam logic [8:0] TEMP_BASE = 9'd200;
   localparam logic [8:0] TEMP_MAX  = 9'd500;
   localparam logic [6:0] POWER_MAX = 7'd100;

   typedef struct packed {
      logic latch;
      logic exec;
      logic mul;
      logic div_start;
      logic est;
      logic load_out;
   } cls_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic mon_en;
      logic div_busy;
   } cls_sts_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [LevelW-1:0] goal;
      logic [LevelW-1:0] level;
      logic              busy;
      logic [CountW-1:0] count;
   } lamp_type;

endpackage

// ===== rtl/cls_div.sv =====
module cls_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cls_pkg::DivW-1:0]  dividend,
   input  logic [cls_pkg::RemW-1:0]  divisor,
   output logic                      busy,
   output logic [cls_pkg::DivW-1:0]  quotient
);
   import cls_pkg::*;

   logic              busy_ff, busy_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [DivW-1:0]   quo_ff, quo_in;
   logic [RemW-1:0]   rem_ff, rem_in;
   logic [RemW:0]     trial;
   logic              fits;

   // One quotient bit per cycle, restoring form.
   assign trial = {rem_ff, quo_ff[DivW-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = StepW'(DivW - 1);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? RemW'(trial - {1'b0, divisor}) : trial[RemW-1:0];
         quo_in  = {quo_ff[DivW-2:0], fits};
         step_in = step_ff - StepW'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/cls_ctrl.sv =====
module cls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cls_pkg::cls_cmd_type cmd,
   input  cls_pkg::cls_sts_type sts
);
   import cls_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIVS = 3'd3;
   localparam logic [2:0] S_DIVW = 3'd4;
   localparam logic [2:0] S_EST  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (sts.is_tick && sts.mon_en) ? S_MUL : S_OUT;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (!sts.div_busy) begin
               state_in = S_EST;
            end
         end
         S_EST: begin
            cmd.est  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // The result register frees up in the same cycle its beat is taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_EXEC)
      else $error("accepted beat did not start execution");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EST |-> !sts.div_busy)
      else $error("estimate applied while the dividers still run");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !(rsp_valid_ff && rsp_stall))
      |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not presented after the output stage");

endmodule

// ===== rtl/cls_dp.sv =====
module cls_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  cls_pkg::cls_cmd_type         cmd,
   output cls_pkg::cls_sts_type         sts,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_index,
   input  logic [cls_pkg::LevelW-1:0]   csr_wdata,
   input  logic [2:0]                   req_cmd,
   input  logic signed [10:0]           req_brightness_request,
   input  logic                         req_estop_value,
   output logic [1:0]                   rsp_status,
   output logic [2:0]                   rsp_cover_state,
   output logic                         rsp_cover_moving,
   output logic [2:0]                   rsp_lamp_state,
   output logic                         rsp_lamp_changing,
   output logic [cls_pkg::LevelW-1:0]   rsp_brightness_now,
   output logic [8:0]                   rsp_temperature_tenths,
   output logic [6:0]                   rsp_power_percent,
   output logic                         rsp_overheat,
   output logic                         rsp_estop_active
);
   import cls_pkg::*;

   // Configuration registers.
   logic [LevelW-1:0]  maxb_ff, maxb_in;
   logic [CountW-1:0]  travel_ff, travel_in;
   logic [CountW-1:0]  warm_ff, warm_in;
   logic [CountW-1:0]  cool_ff, cool_in;
   logic signed [7:0]  maxt_ff, maxt_in;
   logic               cpres_ff, cpres_in;
   logic               lpres_ff, lpres_in;
   logic               mon_ff, mon_in;

   // Unit state.
   logic [2:0]         cover_mode_ff, cover_mode_in;
   logic               cover_to_open_ff, cover_to_open_in;
   logic               cover_busy_ff, cover_busy_in;
   logic [CountW-1:0]  cover_count_ff, cover_count_in;
   lamp_type           lamp_ff, lamp_in;
   logic               estop_ff, estop_in;
   logic               hot_ff, hot_in;
   logic [8:0]         temp_ff, temp_in;
   logic [6:0]         power_ff, power_in;
   logic [1:0]         status_ff, status_in;

   // Latched input beat and estimate operands.
   logic [2:0]         cmd_ff;
   logic signed [10:0] breq_ff;
   logic               estv_ff;
   logic [DivW-1:0]    lvl300_ff, lvl100_ff, lhs_ff;
   logic signed [ProdW-1:0] prod_ff;

   logic [LevelW-1:0]  clamped;
   logic [DivW-1:0]    lvl300_w, lvl100_w, maxb200_w;
   logic signed [ProdW-1:0] maxt_ext, maxb_ext;
   logic signed [RhsW-1:0]  rhs_w, lhs_ext;
   logic [DivW-1:0]    q300, q100;
   logic               busy_t, busy_p;

   function automatic lamp_type lamp_finish(lamp_type l);
      lamp_type r;
      r = l;
      if (l.goal != '0) begin
         r.level = l.goal;
         r.mode  = LP_READY;
      end else begin
         r.level = '0;
         r.mode  = LP_OFF;
      end
      r.busy  = 1'b0;
      r.count = '0;
      return r;
   endfunction

   function automatic lamp_type lamp_begin(lamp_type l, logic [LevelW-1:0] goal,
                                           logic [CountW-1:0] warm,
                                           logic [CountW-1:0] cool);
      lamp_type r;
      r       = l;
      r.goal  = goal;
      r.mode  = LP_NOTREADY;
      r.busy  = 1'b1;
      r.count = (goal != '0) ? warm : cool;
      if (r.count == '0) begin
         r = lamp_finish(r);
      end
      return r;
   endfunction

   always_comb begin
      if (breq_ff < 0) begin
         clamped = '0;
      end else if (breq_ff[LevelW-1:0] > maxb_ff) begin
         clamped = maxb_ff;
      end else begin
         clamped = breq_ff[LevelW-1:0];
      end
   end

   assign lvl300_w  = DivW'(lamp_ff.level) * DivW'(300);
   assign lvl100_w  = DivW'(lamp_ff.level) * DivW'(100);
   assign maxb200_w = DivW'(maxb_ff) * DivW'(200);
   assign maxt_ext  = ProdW'(maxt_ff);
   assign maxb_ext  = $signed(ProdW'(maxb_ff));
   assign rhs_w     = RhsW'(prod_ff) * RhsW'(10);
   assign lhs_ext   = $signed(RhsW'(lhs_ff));

   always_comb begin
      maxb_in          = maxb_ff;
      travel_in        = travel_ff;
      warm_in          = warm_ff;
      cool_in          = cool_ff;
      maxt_in          = maxt_ff;
      cpres_in         = cpres_ff;
      lpres_in         = lpres_ff;
      mon_in           = mon_ff;
      cover_mode_in    = cover_mode_ff;
      cover_to_open_in = cover_to_open_ff;
      cover_busy_in    = cover_busy_ff;
      cover_count_in   = cover_count_ff;
      lamp_in          = lamp_ff;
      estop_in         = estop_ff;
      hot_in           = hot_ff;
      temp_in          = temp_ff;
      power_in         = power_ff;
      status_in        = status_ff;

      if (csr_we) begin
         case (csr_index)
            REG_MAX_BRIGHT: begin
               if (csr_wdata != '0) begin
                  maxb_in = csr_wdata;
               end
            end
            REG_TRAVEL: begin
               if (csr_wdata[CountW-1:0] != '0) begin
                  travel_in = csr_wdata[CountW-1:0];
               end
            end
            REG_WARMUP:   warm_in = csr_wdata[CountW-1:0];
            REG_COOLDOWN: cool_in = csr_wdata[CountW-1:0];
            REG_MAX_TEMP: maxt_in = $signed(csr_wdata[7:0]);
            REG_COVER_PRES: begin
               cpres_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  cover_mode_in  = CV_ABSENT;
                  cover_busy_in  = 1'b0;
                  cover_count_in = '0;
               end else if (cover_mode_ff == CV_ABSENT) begin
                  cover_mode_in = CV_UNKNOWN;
               end
            end
            REG_LAMP_PRES: begin
               lpres_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  lamp_in.mode  = LP_ABSENT;
                  lamp_in.busy  = 1'b0;
                  lamp_in.count = '0;
               end else if (lamp_ff.mode == LP_ABSENT) begin
                  lamp_in.mode = LP_UNKNOWN;
               end
            end
            REG_MONITOR: mon_in = csr_wdata[0];
            default: begin
            end
         endcase
      end else if (cmd.exec) begin
         status_in = STAT_OK;
         case (cmd_ff)
            CMD_TICK: begin
               if (cover_busy_ff) begin
                  if (cover_count_ff != '0) begin
                     cover_count_in = cover_count_ff - CountW'(1);
                  end
                  if (cover_count_in == '0) begin
                     cover_mode_in = cover_to_open_ff ? CV_OPEN : CV_CLOSED;
                     cover_busy_in = 1'b0;
                  end
               end
               if (lamp_ff.busy) begin
                  if (lamp_ff.count != '0) begin
                     lamp_in.count = lamp_ff.count - CountW'(1);
                  end
                  if (lamp_in.count == '0) begin
                     lamp_in = lamp_finish(lamp_in);
                  end
               end
            end
            CMD_OPEN, CMD_CLOSE: begin
               if (!cpres_ff) begin
                  status_in = STAT_ABSENT;
               end else if (cover_mode_ff ==
                            ((cmd_ff == CMD_OPEN) ? CV_OPEN : CV_CLOSED)) begin
                  status_in = STAT_OK;
               end else if (estop_ff) begin
                  status_in = STAT_ESTOP;
               end else begin
                  cover_mode_in    = CV_MOVING;
                  cover_to_open_in = cmd_ff == CMD_OPEN;
                  cover_busy_in    = 1'b1;
                  cover_count_in   = travel_ff;
               end
            end
            CMD_HALT: begin
               if (cpres_ff) begin
                  cover_busy_in  = 1'b0;
                  cover_count_in = '0;
               end
            end
            CMD_LON: begin
               if (!lpres_ff) begin
                  status_in = STAT_ABSENT;
               end else if (estop_ff) begin
                  status_in = STAT_ESTOP;
               end else if (hot_ff) begin
                  status_in = STAT_HOT;
               end else begin
                  lamp_in = lamp_begin(lamp_ff, clamped, warm_ff, cool_ff);
               end
            end
            CMD_LOFF: begin
               if (lpres_ff) begin
                  lamp_in = lamp_begin(lamp_ff, '0, warm_ff, cool_ff);
               end
            end
            CMD_SETBR: begin
               if (!lpres_ff) begin
                  status_in = STAT_ABSENT;
               end else begin
                  lamp_in.goal = clamped;
                  // A ready lamp is switched on again at the new goal, unless an e-stop or overheat blocks it.
                  if (lamp_ff.mode == LP_READY) begin
                     if (estop_ff) begin
                        status_in = STAT_ESTOP;
                     end else if (hot_ff) begin
                        status_in = STAT_HOT;
                     end else begin
                        lamp_in = lamp_begin(lamp_ff, clamped, warm_ff, cool_ff);
                     end
                  end
               end
            end
            CMD_ESTOP: begin
               estop_in = estv_ff;
               if (estv_ff) begin
                  if (cpres_ff) begin
                     cover_busy_in  = 1'b0;
                     cover_count_in = '0;
                  end
                  if (lpres_ff) begin
                     lamp_in = lamp_begin(lamp_ff, '0, warm_ff, cool_ff);
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.est) begin
         temp_in  = (q300 > DivW'(300)) ? TEMP_MAX : 9'(q300) + TEMP_BASE;
         power_in = (q100 > DivW'(POWER_MAX)) ? POWER_MAX : 7'(q100);
         if (lhs_ext > rhs_w) begin
            hot_in = 1'b1;
            // No new off sequence if one runs already, the lamp rests off or the lamp is absent.
            if (!(lamp_ff.busy && lamp_ff.goal == '0) &&
                !(!lamp_ff.busy && lamp_ff.mode == LP_OFF) && lpres_ff) begin
               lamp_in = lamp_begin(lamp_ff, '0, warm_ff, cool_ff);
            end
         end else begin
            hot_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxb_ff          <= LevelW'(255);
         travel_ff        <= CountW'(30);
         warm_ff          <= CountW'(5);
         cool_ff          <= CountW'(3);
         maxt_ff          <= 8'sd60;
         cpres_ff         <= 1'b1;
         lpres_ff         <= 1'b1;
         mon_ff           <= 1'b1;
         cover_mode_ff    <= CV_CLOSED;
         cover_to_open_ff <= 1'b0;
         cover_busy_ff    <= 1'b0;
         cover_count_ff   <= '0;
         lamp_ff.mode     <= LP_OFF;
         lamp_ff.goal     <= '0;
         lamp_ff.level    <= '0;
         lamp_ff.busy     <= 1'b0;
         lamp_ff.count    <= '0;
         estop_ff         <= 1'b0;
         hot_ff           <= 1'b0;
         temp_ff          <= TEMP_BASE;
         power_ff         <= '0;
         status_ff        <= STAT_OK;
      end else begin
         maxb_ff          <= maxb_in;
         travel_ff        <= travel_in;
         warm_ff          <= warm_in;
         cool_ff          <= cool_in;
         maxt_ff          <= maxt_in;
         cpres_ff         <= cpres_in;
         lpres_ff         <= lpres_in;
         mon_ff           <= mon_in;
         cover_mode_ff    <= cover_mode_in;
         cover_to_open_ff <= cover_to_open_in;
         cover_busy_ff    <= cover_busy_in;
         cover_count_ff   <= cover_count_in;
         lamp_ff          <= lamp_in;
         estop_ff         <= estop_in;
         hot_ff           <= hot_in;
         temp_ff          <= temp_in;
         power_ff         <= power_in;
         status_ff        <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff  <= req_cmd;
         breq_ff <= req_brightness_request;
         estv_ff <= req_estop_value;
      end
      if (cmd.mul) begin
         lvl300_ff <= lvl300_w;
         lvl100_ff <= lvl100_w;
         lhs_ff    <= maxb200_w + lvl300_w;
         prod_ff   <= maxt_ext * maxb_ext;
      end
   end

   cls_div u_div_temp (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (lvl300_ff),
      .divisor  (maxb_ff),
      .busy     (busy_t),
      .quotient (q300)
   );

   cls_div u_div_power (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (lvl100_ff),
      .divisor  (maxb_ff),
      .busy     (busy_p),
      .quotient (q100)
   );

   assign sts.is_tick  = cmd_ff == CMD_TICK;
   assign sts.mon_en   = mon_ff;
   assign sts.div_busy = busy_t || busy_p;

   // Result register: a snapshot of the state once the beat's work is done.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status             <= status_ff;
         rsp_cover_state        <= cover_mode_ff;
         rsp_cover_moving       <= cover_busy_ff;
         rsp_lamp_state         <= lamp_ff.mode;
         rsp_lamp_changing      <= lamp_ff.busy;
         rsp_brightness_now     <= lamp_ff.level;
         rsp_temperature_tenths <= temp_ff;
         rsp_power_percent      <= power_ff;
         rsp_overheat           <= hot_ff;
         rsp_estop_active       <= estop_ff;
      end
   end

   a_cover_busy_moving: assert property (@(posedge clock) disable iff (reset)
      cover_busy_ff |-> cover_mode_ff == CV_MOVING)
      else $error("cover timer runs outside the moving state");

   a_lamp_busy_notready: assert property (@(posedge clock) disable iff (reset)
      lamp_ff.busy |-> lamp_ff.mode == LP_NOTREADY)
      else $error("lamp sequence runs outside the not-ready state");

   a_estimate_range: assert property (@(posedge clock) disable iff (reset)
      (temp_ff <= TEMP_MAX) && (power_ff <= POWER_MAX))
      else $error("estimate out of range");

endmodule

// ===== rtl/cover_and_lamp_sequencer.sv =====
// Cover and lamp sequencer. Each input beat is a one-second tick or a command; each
// beat yields exactly one result beat. The block takes one beat at a time; a tick with
// monitoring enabled takes longer than a command, as it waits for the two 19-step
// serial dividers that form the temperature and power estimates in parallel.
// req_stall stays high from acceptance until the result is loaded into the output
// register; a finished result may wait there while the next beat is already
// accepted. Configuration writes are taken whenever the block is idle.
module cover_and_lamp_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [10:0] req_brightness_request,
   input  logic               req_estop_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_cover_state,
   output logic               rsp_cover_moving,
   output logic [2:0]         rsp_lamp_state,
   output logic               rsp_lamp_changing,
   output logic [9:0]         rsp_brightness_now,
   output logic [8:0]         rsp_temperature_tenths,
   output logic [6:0]         rsp_power_percent,
   output logic               rsp_overheat,
   output logic               rsp_estop_active,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [9:0]         csr_wdata
);
   import cls_pkg::*;

   cls_cmd_type cmd;
   cls_sts_type sts;

   cls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   cls_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_cmd                (req_cmd),
      .req_brightness_request (req_brightness_request),
      .req_estop_value        (req_estop_value),
      .rsp_status             (rsp_status),
      .rsp_cover_state        (rsp_cover_state),
      .rsp_cover_moving       (rsp_cover_moving),
      .rsp_lamp_state         (rsp_lamp_state),
      .rsp_lamp_changing      (rsp_lamp_changing),
      .rsp_brightness_now     (rsp_brightness_now),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_power_percent      (rsp_power_percent),
      .rsp_overheat           (rsp_overheat),
      .rsp_estop_active       (rsp_estop_active)
   );

endmodule
